### rtl/frl_pkg.sv
// ----------------------------------------------------------------------------
// frl_pkg
// Shared types and constants of the framed sector ring logger: request,
// status, run state and register codes, defaults and the result record.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int SECTOR_BYTES_DEF = 512;
  localparam int NUM_SECTORS_DEF  = 16;
  localparam int MAX_IDS_DEF      = 32;

  localparam int FRAME_EXTRA = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_IDS    = 3'd0,
    CFG_BEGIN_ONE  = 3'd1,
    CFG_BEGIN_TWO  = 3'd2,
    CFG_END_FLAG   = 3'd3,
    CFG_MAX_CHUNK  = 3'd4
  } cfg_idx_t;

  localparam logic [5:0] NUM_IDS_RST   = 6'd32;
  localparam logic [7:0] FLAG_RST      = 8'd0;
  localparam logic [4:0] MAX_CHUNK_RST = 5'd16;

  typedef enum logic [2:0] {
    REQ_START   = 3'd0,
    REQ_HEADER  = 3'd1,
    REQ_PAYLOAD = 3'd2,
    REQ_DRAIN   = 3'd3,
    REQ_STOP    = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID_ID = 3'd1,
    ST_NOT_LOG    = 3'd2,
    ST_FULL       = 3'd3,
    ST_BUSY       = 3'd4,
    ST_NO_MSG     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RUN_IDLE     = 2'd0,
    RUN_LOGGING  = 2'd1,
    RUN_STOPPING = 2'd2
  } run_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        sector_ready;
    logic        chunk_valid;
    logic [3:0]  chunk_start;
    logic [4:0]  chunk_sectors;
    logic        partial_valid;
    logic [9:0]  partial_bytes;
    logic [1:0]  log_state;
    logic [31:0] total_count;
    logic [31:0] lost_count;
  } res_t;

endpackage

### rtl/frl_if.sv
// ----------------------------------------------------------------------------
// frl_in_if / frl_out_if
// Valid/ready channels of the logger: request items in, result items out.
// ----------------------------------------------------------------------------
interface frl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  msg_id;
  logic [15:0] msg_len;
  logic [7:0]  payload_byte;
  logic        payload_last;

  modport source (output valid, req_type, msg_id, msg_len, payload_byte, payload_last,
                  input ready);
  modport sink (input valid, req_type, msg_id, msg_len, payload_byte, payload_last,
                output ready);
endinterface

interface frl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        sector_ready;
  logic        chunk_valid;
  logic [3:0]  chunk_start;
  logic [4:0]  chunk_sectors;
  logic        partial_valid;
  logic [9:0]  partial_bytes;
  logic [1:0]  log_state;
  logic [31:0] total_count;
  logic [31:0] lost_count;

  modport source (output valid, status, sector_ready, chunk_valid, chunk_start,
                  chunk_sectors, partial_valid, partial_bytes, log_state,
                  total_count, lost_count,
                  input ready);
  modport sink (input valid, status, sector_ready, chunk_valid, chunk_start,
                chunk_sectors, partial_valid, partial_bytes, log_state,
                total_count, lost_count,
                output ready);
endinterface

### rtl/framed_sector_ring_logger.sv
// ----------------------------------------------------------------------------
// framed_sector_ring_logger
// Binary log framer writing begin/id/payload/end frames byte by byte into a
// sectored ring, with per-id message counters and run-based draining.
//
// Usage:
//   in_ch carries one request per transfer: start, message header, payload
//   byte, drain or stop. out_ch returns exactly one result per request.
//   cfg_we/cfg_index/cfg_wdata write the five setup registers while idle.
// Timing:
//   one byte writer is shared by all framing work, one byte per cycle: an
//   accepted header writes its two begin flags and its id, a payload byte
//   writes itself and then the end flag if it is the last; a header with a
//   valid id first reads its counters. in_ch.ready is high only while no
//   item is in work.
// Reset:
//   pointers, run state, counters and setup registers return to defaults;
//   the counter table is cleared at once through per-id valid bits, the
//   log store itself is not cleared.
// Stall:
//   a finished result sits in the output register; the next item may be
//   taken meanwhile, and its own result waits until out_ch.ready frees it.
// ----------------------------------------------------------------------------
module framed_sector_ring_logger #(
  parameter int SECTOR_BYTES = frl_pkg::SECTOR_BYTES_DEF,
  parameter int NUM_SECTORS  = frl_pkg::NUM_SECTORS_DEF,
  parameter int MAX_IDS      = frl_pkg::MAX_IDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [frl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  frl_in_if.sink                         in_ch,
  frl_out_if.source                      out_ch
);
  import frl_pkg::*;

  localparam int PW  = $clog2(NUM_SECTORS);
  localparam int FW  = $clog2(SECTOR_BYTES + 1);
  localparam int AW  = $clog2(SECTOR_BYTES * NUM_SECTORS);
  localparam int IW  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CW  = (PW + 1 > 5) ? PW + 1 : 5;
  localparam int LW  = 17;
  localparam int MEM_DEPTH = SECTOR_BYTES * NUM_SECTORS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_HDR  = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } st_t;

  st_t st_r, st_nxt;

  logic [2:0]  req_r;
  logic [7:0]  id_r;
  logic [15:0] len_r;
  logic [7:0]  pb_r;
  logic        pl_r;

  logic [5:0] nid_r;
  logic [7:0] bf1_r, bf2_r, ef_r;
  logic [4:0] mcs_r;

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [1:0]    run_r, run_nxt;
  logic          open_r, open_nxt;
  logic          adv_r, adv_nxt;

  logic [2:0][7:0] pk_r, pk_nxt;
  logic [1:0]      pk_cnt_r, pk_cnt_nxt;

  res_t res_r, res_nxt;
  res_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [7:0]   log_store [MEM_DEPTH];
  logic         mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]   mem_wdata;

  logic [63:0]        cnt_mem [MAX_IDS];
  logic [MAX_IDS-1:0] cnt_vld_r, cnt_vld_nxt;
  logic [63:0]        cnt_q_r;
  logic               cnt_qv_r;
  logic               cnt_we;
  logic [63:0]        cnt_wdata;
  logic [IW-1:0]      cnt_idx;

  logic          in_fire;
  logic [8:0]    ids;
  logic [PW-1:0] head_inc;
  logic [31:0]   acc_cur, lost_cur;
  logic [LW-1:0] room, need;
  logic [CW-1:0] to_end, in_buf, cap, run_len, tail_sum;
  logic [PW-1:0] put_head;
  logic [FW-1:0] put_fill;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign cnt_idx     = id_r[IW-1:0];

  assign ids      = ({3'b000, nid_r} > 9'(MAX_IDS)) ? 9'(MAX_IDS) : {3'b000, nid_r};
  assign head_inc = (head_r == PW'(NUM_SECTORS - 1)) ? '0 : head_r + 1'b1;
  assign acc_cur  = cnt_qv_r ? cnt_q_r[63:32] : '0;
  assign lost_cur = cnt_qv_r ? cnt_q_r[31:0] : '0;
  assign room     = LW'(SECTOR_BYTES) - LW'(fill_r);
  assign need     = LW'(len_r) + LW'(FRAME_EXTRA);

  assign to_end   = CW'(NUM_SECTORS) - CW'(tail_r);
  assign in_buf   = (head_r > tail_r) ? CW'(head_r) - CW'(tail_r) : to_end + CW'(head_r);
  assign cap      = (mcs_r == '0) ? CW'(1) : CW'(mcs_r);
  assign run_len  = (in_buf < to_end) ? ((in_buf > cap) ? cap : in_buf)
                                      : ((to_end > cap) ? cap : to_end);
  assign tail_sum = CW'(tail_r) + run_len;

  // byte writer: advance to the next sector when the current one is full
  assign put_head = (fill_r == FW'(SECTOR_BYTES)) ? head_inc : head_r;
  assign put_fill = (fill_r == FW'(SECTOR_BYTES)) ? '0 : fill_r;

  always_comb begin
    st_nxt        = st_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    run_nxt       = run_r;
    open_nxt      = open_r;
    adv_nxt       = adv_r;
    pk_nxt        = pk_r;
    pk_cnt_nxt    = pk_cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cnt_vld_nxt   = cnt_vld_r;
    cnt_we        = 1'b0;
    cnt_wdata     = cnt_q_r;
    mem_we        = 1'b0;
    mem_addr      = AW'(put_head) * AW'(SECTOR_BYTES) + AW'(put_fill);
    mem_wdata     = pk_r[0];

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt = '0;
        adv_nxt = 1'b0;
        st_nxt  = S_DONE;
        case (req_r)
          REQ_START: begin
            if (run_r != RUN_IDLE) begin
              res_nxt.status = ST_BUSY;
            end else begin
              head_nxt    = '0;
              tail_nxt    = '0;
              fill_nxt    = '0;
              open_nxt    = 1'b0;
              cnt_vld_nxt = '0;
              run_nxt     = RUN_LOGGING;
            end
          end
          REQ_HEADER: begin
            if ({1'b0, id_r} >= ids) begin
              res_nxt.status = ST_INVALID_ID;
            end else begin
              st_nxt = S_HDR;
            end
          end
          REQ_PAYLOAD: begin
            if (!open_r) begin
              res_nxt.status = ST_NO_MSG;
            end else begin
              pk_nxt[0] = pb_r;
              pk_nxt[1] = ef_r;
              pk_nxt[2] = '0;
              if (pl_r) begin
                pk_cnt_nxt = 2'd2;
                open_nxt   = 1'b0;
              end else begin
                pk_cnt_nxt = 2'd1;
              end
              st_nxt = S_PUT;
            end
          end
          REQ_DRAIN: begin
            if (run_r == RUN_IDLE) begin
              res_nxt.status = ST_NOT_LOG;
            end else if (head_r != tail_r) begin
              res_nxt.chunk_valid   = 1'b1;
              res_nxt.chunk_start   = 4'(tail_r);
              res_nxt.chunk_sectors = 5'(run_len);
              tail_nxt = (tail_sum == CW'(NUM_SECTORS)) ? '0 : PW'(tail_sum);
            end else if (run_r == RUN_STOPPING) begin
              if (fill_r != '0) begin
                res_nxt.partial_valid = 1'b1;
                res_nxt.partial_bytes = 10'(fill_r);
              end
              open_nxt = 1'b0;
              run_nxt  = RUN_IDLE;
            end
          end
          REQ_STOP: begin
            if (run_r == RUN_LOGGING) begin
              run_nxt = RUN_STOPPING;
            end else begin
              res_nxt.status = ST_NOT_LOG;
            end
          end
          default: begin
          end
        endcase
      end
      S_HDR: begin
        st_nxt = S_DONE;
        res_nxt.total_count = acc_cur;
        res_nxt.lost_count  = lost_cur;
        if (run_r != RUN_LOGGING) begin
          res_nxt.status = ST_NOT_LOG;
        end else if (open_r) begin
          res_nxt.status = ST_BUSY;
        end else if (room < need && head_inc == tail_r) begin
          res_nxt.status     = ST_FULL;
          res_nxt.lost_count = lost_cur + 32'd1;
          cnt_we             = 1'b1;
          cnt_wdata          = {acc_cur, lost_cur + 32'd1};
          cnt_vld_nxt[cnt_idx] = 1'b1;
        end else begin
          res_nxt.total_count = acc_cur + 32'd1;
          cnt_we              = 1'b1;
          cnt_wdata           = {acc_cur + 32'd1, lost_cur};
          cnt_vld_nxt[cnt_idx] = 1'b1;
          open_nxt   = 1'b1;
          pk_nxt[0]  = bf1_r;
          pk_nxt[1]  = bf2_r;
          pk_nxt[2]  = id_r;
          pk_cnt_nxt = 2'd3;
          st_nxt     = S_PUT;
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        head_nxt   = put_head;
        fill_nxt   = put_fill + 1'b1;
        if (fill_r == FW'(SECTOR_BYTES)) begin
          adv_nxt = 1'b1;
        end
        pk_nxt[0]  = pk_r[1];
        pk_nxt[1]  = pk_r[2];
        pk_nxt[2]  = '0;
        pk_cnt_nxt = pk_cnt_r - 1'b1;
        if (pk_cnt_r == 2'd1) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt              = res_r;
          out_nxt.sector_ready = adv_r;
          out_nxt.log_state    = run_r;
          out_valid_nxt        = 1'b1;
          st_nxt               = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      run_r       <= RUN_IDLE;
      open_r      <= 1'b0;
      adv_r       <= 1'b0;
      pk_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_vld_r   <= '0;
      cnt_qv_r    <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      run_r       <= run_nxt;
      open_r      <= open_nxt;
      adv_r       <= adv_nxt;
      pk_cnt_r    <= pk_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      cnt_qv_r    <= cnt_vld_r[cnt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_ch.req_type;
      id_r  <= in_ch.msg_id;
      len_r <= in_ch.msg_len;
      pb_r  <= in_ch.payload_byte;
      pl_r  <= in_ch.payload_last;
    end
    pk_r  <= pk_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nid_r <= NUM_IDS_RST;
      bf1_r <= FLAG_RST;
      bf2_r <= FLAG_RST;
      ef_r  <= FLAG_RST;
      mcs_r <= MAX_CHUNK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_IDS:   nid_r <= cfg_wdata[5:0];
        CFG_BEGIN_ONE: bf1_r <= cfg_wdata;
        CFG_BEGIN_TWO: bf2_r <= cfg_wdata;
        CFG_END_FLAG:  ef_r  <= cfg_wdata;
        CFG_MAX_CHUNK: mcs_r <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // log store, write only
  always_ff @(posedge clk) begin
    if (mem_we) begin
      log_store[mem_addr] <= mem_wdata;
    end
  end

  // per-id counters: accepted in the upper half, lost in the lower half
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_idx] <= cnt_wdata;
    end
    cnt_q_r <= cnt_mem[cnt_idx];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.sector_ready  = out_r.sector_ready;
  assign out_ch.chunk_valid   = out_r.chunk_valid;
  assign out_ch.chunk_start   = out_r.chunk_start;
  assign out_ch.chunk_sectors = out_r.chunk_sectors;
  assign out_ch.partial_valid = out_r.partial_valid;
  assign out_ch.partial_bytes = out_r.partial_bytes;
  assign out_ch.log_state     = out_r.log_state;
  assign out_ch.total_count   = out_r.total_count;
  assign out_ch.lost_count    = out_r.lost_count;

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (st_r == S_EXEC))
    else $error("accepted request did not start work");

  a_queue_only_in_put: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_PUT) |-> (pk_cnt_r == '0))
    else $error("byte queue not empty outside the write loop");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(SECTOR_BYTES))
    else $error("fill index past sector end");

  a_open_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (run_r != RUN_IDLE))
    else $error("message open while idle");

endmodule

### verif/framed_sector_ring_logger_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_sector_ring_logger_checker
// Watches the configuration port and both channels of the logger. It keeps
// its own copy of the ring pointers, run state and per-id counters, works out
// the result of every request transfer and compares each result transfer,
// field by field, against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module framed_sector_ring_logger_checker #(
  parameter int SECTOR_BYTES = frl_pkg::SECTOR_BYTES_DEF,
  parameter int NUM_SECTORS  = frl_pkg::NUM_SECTORS_DEF,
  parameter int MAX_IDS      = frl_pkg::MAX_IDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [frl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  frl_in_if                              in_mon,
  frl_out_if                             out_mon,
  output int                             fail_count,
  output int                             pending,
  output int                             checked,
  output int                             full_hits,
  output int                             chunk_hits,
  output int                             flush_hits
);
  import frl_pkg::*;

  int          head_sec;
  int          tail_sec;
  int          fill;
  run_t        run_st;
  bit          msg_open;
  bit          sector_done;
  logic [31:0] accepted_cnt [MAX_IDS];
  logic [31:0] lost_cnt [MAX_IDS];

  logic [5:0]  num_ids_reg;
  logic [7:0]  begin_one_reg;
  logic [7:0]  begin_two_reg;
  logic [7:0]  end_flag_reg;
  logic [4:0]  max_chunk_reg;

  res_t        expected_results [$];

  function automatic void restart_ring();
    head_sec = 0;
    tail_sec = 0;
    fill     = 0;
    msg_open = 1'b0;
    for (int i = 0; i < MAX_IDS; i++) begin
      accepted_cnt[i] = '0;
      lost_cnt[i]     = '0;
    end
  endfunction

  // head moves on only when a byte has to land in a full sector
  function automatic void append_byte();
    if (fill >= SECTOR_BYTES) begin
      head_sec    = (head_sec + 1) % NUM_SECTORS;
      fill        = 0;
      sector_done = 1'b1;
    end
    fill++;
  endfunction

  function automatic res_t log_request(input logic [2:0] req, input logic [7:0] id,
                                       input logic [15:0] len, input logic last);
    res_t r;
    int   id_lim;
    int   to_end;
    int   used;
    int   run;
    int   cap;
    r           = '0;
    sector_done = 1'b0;
    id_lim      = (num_ids_reg > MAX_IDS) ? MAX_IDS : int'(num_ids_reg);
    case (req)
      REQ_START: begin
        if (run_st != RUN_IDLE) begin
          r.status = ST_BUSY;
        end else begin
          restart_ring();
          run_st = RUN_LOGGING;
        end
      end
      REQ_HEADER: begin
        if (int'(id) >= id_lim) begin
          r.status = ST_INVALID_ID;
        end else begin
          if (run_st != RUN_LOGGING) begin
            r.status = ST_NOT_LOG;
          end else if (msg_open) begin
            r.status = ST_BUSY;
          end else if ((SECTOR_BYTES - fill) < (int'(len) + FRAME_EXTRA) &&
                       ((head_sec + 1) % NUM_SECTORS) == tail_sec) begin
            lost_cnt[id] = lost_cnt[id] + 1;
            r.status     = ST_FULL;
          end else begin
            append_byte();
            append_byte();
            append_byte();
            msg_open         = 1'b1;
            accepted_cnt[id] = accepted_cnt[id] + 1;
          end
          r.total_count = accepted_cnt[id];
          r.lost_count  = lost_cnt[id];
        end
      end
      REQ_PAYLOAD: begin
        if (!msg_open) begin
          r.status = ST_NO_MSG;
        end else begin
          append_byte();
          if (last) begin
            append_byte();
            msg_open = 1'b0;
          end
        end
      end
      REQ_DRAIN: begin
        if (run_st == RUN_IDLE) begin
          r.status = ST_NOT_LOG;
        end else if (head_sec != tail_sec) begin
          to_end = NUM_SECTORS - tail_sec;
          used   = (head_sec > tail_sec) ? head_sec - tail_sec : to_end + head_sec;
          cap    = (max_chunk_reg == 0) ? 1 : int'(max_chunk_reg);
          run    = (used < to_end) ? used : to_end;
          if (run > cap) begin
            run = cap;
          end
          r.chunk_valid   = 1'b1;
          r.chunk_start   = 4'(tail_sec);
          r.chunk_sectors = 5'(run);
          tail_sec        = (tail_sec + run) % NUM_SECTORS;
        end else if (run_st == RUN_STOPPING) begin
          if (fill != 0) begin
            r.partial_valid = 1'b1;
            r.partial_bytes = 10'(fill);
          end
          msg_open = 1'b0;
          run_st   = RUN_IDLE;
        end
      end
      REQ_STOP: begin
        if (run_st == RUN_LOGGING) begin
          run_st = RUN_STOPPING;
        end else begin
          r.status = ST_NOT_LOG;
        end
      end
      default: begin
      end
    endcase
    r.sector_ready = sector_done;
    r.log_state    = run_st;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      restart_ring();
      run_st        = RUN_IDLE;
      num_ids_reg   = NUM_IDS_RST;
      begin_one_reg = FLAG_RST;
      begin_two_reg = FLAG_RST;
      end_flag_reg  = FLAG_RST;
      max_chunk_reg = MAX_CHUNK_RST;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_IDS:   num_ids_reg   = cfg_wdata[5:0];
          CFG_BEGIN_ONE: begin_one_reg = cfg_wdata;
          CFG_BEGIN_TWO: begin_two_reg = cfg_wdata;
          CFG_END_FLAG:  end_flag_reg  = cfg_wdata;
          CFG_MAX_CHUNK: max_chunk_reg = cfg_wdata[4:0];
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        want = log_request(in_mon.req_type, in_mon.msg_id, in_mon.msg_len,
                           in_mon.payload_last);
        if (want.status == ST_FULL) full_hits++;
        if (want.chunk_valid) chunk_hits++;
        if (want.partial_valid) flush_hits++;
        expected_results.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding, status %0h",
                   $time, out_mon.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("sector_ready", want.sector_ready, out_mon.sector_ready);
          check_field("chunk_valid", want.chunk_valid, out_mon.chunk_valid);
          check_field("chunk_start", want.chunk_start, out_mon.chunk_start);
          check_field("chunk_sectors", want.chunk_sectors, out_mon.chunk_sectors);
          check_field("partial_valid", want.partial_valid, out_mon.partial_valid);
          check_field("partial_bytes", want.partial_bytes, out_mon.partial_bytes);
          check_field("log_state", want.log_state, out_mon.log_state);
          check_field("total_count", want.total_count, out_mon.total_count);
          check_field("lost_count", want.lost_count, out_mon.lost_count);
          checked++;
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

### verif/framed_sector_ring_logger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_sector_ring_logger_tb
// Drives the logger through directed corner cases and then random framed
// traffic under several register settings, including a run of short frames
// that nearly fills a sector and one long message spanning into the next. Both
// channels stall in random bursts; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module framed_sector_ring_logger_tb;
  import frl_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frl_in_if  in_ch ();
  frl_out_if out_ch ();

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int chunk_hits;
  int flush_hits;

  bit gaps_on;
  int id_span;
  int sent_items;
  int settings_used;

  framed_sector_ring_logger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  framed_sector_ring_logger_checker log_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits),
    .chunk_hits (chunk_hits),
    .flush_hits (flush_hits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, quiet, pending);
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_req(input logic [2:0] kind, input logic [7:0] id,
                          input logic [15:0] len, input logic [7:0] data,
                          input logic last);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= kind;
    in_ch.msg_id       <= id;
    in_ch.msg_len      <= len;
    in_ch.payload_byte <= data;
    in_ch.payload_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (kind <= REQ_STOP) sent_items++;
  endtask

  task automatic push_plain(input logic [2:0] kind);
    push_req(kind, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_id();
    if (id_span == 0 || $urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, id_span - 1));
  endfunction

  function automatic logic [15:0] pick_len();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 40));
  endfunction

  task automatic send_message(input logic [7:0] id, input logic [15:0] len,
                              input int nbytes, input bit close);
    push_req(REQ_HEADER, id, len, 8'($urandom), 1'($urandom));
    for (int k = 0; k < nbytes; k++) begin
      push_req(REQ_PAYLOAD, 8'($urandom), 16'($urandom), 8'($urandom),
               close && (k == nbytes - 1));
    end
  endtask

  task automatic close_session(input int drains);
    push_plain(REQ_STOP);
    repeat (drains) push_plain(REQ_DRAIN);
  endtask

  task automatic program_regs(input logic [5:0] ids, input logic [7:0] flag_one,
                              input logic [7:0] flag_two, input logic [7:0] flag_end,
                              input logic [4:0] chunk);
    wait_results();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_IDS;
    cfg_wdata <= {2'($urandom), ids};
    @(posedge clk);
    cfg_index <= CFG_BEGIN_ONE;
    cfg_wdata <= flag_one;
    @(posedge clk);
    cfg_index <= CFG_BEGIN_TWO;
    cfg_wdata <= flag_two;
    @(posedge clk);
    cfg_index <= CFG_END_FLAG;
    cfg_wdata <= flag_end;
    @(posedge clk);
    cfg_index <= CFG_MAX_CHUNK;
    cfg_wdata <= {3'($urandom), chunk};
    @(posedge clk);
    cfg_we  <= 1'b0;
    id_span = (ids > MAX_IDS_DEF) ? MAX_IDS_DEF : int'(ids);
    settings_used++;
  endtask

  task automatic mixed_traffic(input int count, input bit allow_gaps);
    int pick;
    for (int k = 0; k < count; k++) begin
      if (k % 8 == 0) gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_message(pick_id(), pick_len(), $urandom_range(0, 12),
                     $urandom_range(0, 9) != 0);
      end else if (pick < 75) begin
        push_plain(REQ_DRAIN);
      end else if (pick < 80) begin
        close_session($urandom_range(0, 6));
        push_plain(REQ_START);
      end else if (pick < 85) begin
        push_plain(REQ_START);
      end else if (pick < 90) begin
        push_plain(REQ_STOP);
      end else begin
        push_plain(3'($urandom_range(0, 7)));
      end
    end
  endtask

  // short frames fill most of a sector, then one long message crosses into the next
  task automatic flood_ring();
    repeat (80) send_message(8'($urandom_range(0, id_span - 1)),
                             16'($urandom_range(0, 6)), 1, 1'b1);
    repeat (4) push_req(REQ_HEADER, 8'($urandom_range(0, id_span - 1)),
                        16'($urandom_range(600, 65535)), 8'($urandom), 1'($urandom));
    push_plain(REQ_DRAIN);
    send_message(8'($urandom_range(0, id_span - 1)), 16'd0, 200, 1'b1);
    repeat (6) push_plain(REQ_DRAIN);
    repeat (20) send_message(8'($urandom_range(0, id_span - 1)),
                             16'($urandom_range(0, 20)), 1, 1'b1);
    repeat (6) push_plain(REQ_DRAIN);
    wait_results();
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_NUM_IDS;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_START;
    in_ch.msg_id       <= '0;
    in_ch.msg_len      <= '0;
    in_ch.payload_byte <= '0;
    in_ch.payload_last <= 1'b0;
    gaps_on    = 1'b1;
    id_span    = MAX_IDS_DEF;
    sent_items = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(6'd5, 8'hA5, 8'h5A, 8'hFF, 5'd2);
    push_req(REQ_HEADER, 8'd0, 16'd4, 8'h00, 1'b0);
    push_req(REQ_PAYLOAD, 8'd0, 16'd0, 8'h11, 1'b1);
    push_plain(REQ_DRAIN);
    push_plain(REQ_STOP);
    push_plain(REQ_START);
    push_plain(REQ_START);
    push_req(REQ_HEADER, 8'hFF, 16'd0, 8'h00, 1'b0);
    push_req(REQ_HEADER, 8'd5, 16'd0, 8'h00, 1'b0);
    push_req(REQ_HEADER, 8'd4, 16'd0, 8'h00, 1'b0);
    push_req(REQ_HEADER, 8'd1, 16'd0, 8'h00, 1'b0);
    push_req(REQ_PAYLOAD, 8'd0, 16'd0, 8'h00, 1'b0);
    push_req(REQ_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    push_plain(REQ_DRAIN);
    push_req(3'd5, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    push_req(3'd6, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    push_req(3'd7, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    push_req(REQ_HEADER, 8'd0, 16'hFFFF, 8'h00, 1'b0);
    push_req(REQ_PAYLOAD, 8'd0, 16'd0, 8'hAA, 1'b1);
    push_plain(REQ_STOP);
    push_req(REQ_HEADER, 8'd0, 16'd0, 8'h00, 1'b0);
    push_req(REQ_PAYLOAD, 8'd0, 16'd0, 8'h55, 1'b1);
    push_plain(REQ_START);
    push_plain(REQ_DRAIN);
    push_plain(REQ_DRAIN);
    push_plain(REQ_START);
    wait_results();

    mixed_traffic(10, 1'b1);
    close_session(6);

    program_regs(6'd0, 8'h00, 8'h00, 8'h00, 5'd0);
    push_plain(REQ_START);
    mixed_traffic(5, 1'b1);
    close_session(6);

    program_regs(6'd32, 8'hFF, 8'hFF, 8'hFF, 5'd16);
    push_plain(REQ_START);
    mixed_traffic(8, 1'b1);
    close_session(6);
    push_plain(REQ_START);
    gaps_on = 1'b1;
    flood_ring();
    close_session(6);

    program_regs(6'd63, 8'($urandom), 8'($urandom), 8'($urandom), 5'd31);
    push_plain(REQ_START);
    mixed_traffic(6, 1'b1);
    close_session(6);

    program_regs(6'd1, 8'($urandom), 8'($urandom), 8'($urandom), 5'd1);
    push_plain(REQ_START);
    mixed_traffic(6, 1'b1);
    close_session(6);

    program_regs(6'($urandom_range(1, 32)), 8'($urandom), 8'($urandom),
                 8'($urandom), 5'($urandom_range(1, 16)));
    push_plain(REQ_START);
    mixed_traffic(6, 1'b1);
    mixed_traffic(6, 1'b0);

    wait_results();
    repeat (20) @(posedge clk);
    $display("covered %0d requests under %0d register settings, %0d results checked",
             sent_items, settings_used, checked);
    $display("ring full refusals %0d, sector runs drained %0d, partial flushes %0d",
             full_hits, chunk_hits, flush_hits);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/frl_pkg.sv
rtl/frl_if.sv
rtl/framed_sector_ring_logger.sv
verif/framed_sector_ring_logger_checker.sv
verif/framed_sector_ring_logger_tb.sv
